// File: src/dre_pkg.sv
// ----------------------------------------------------------------------------
// dre_pkg
// shared types, constants, microcode step codes and helper functions for the
// date to clock image and epoch seconds block
// ----------------------------------------------------------------------------
package dre_pkg;

  localparam int unsigned EPOCH_YEAR_DEF = 1970;
  localparam int unsigned UPC_W          = 4;

  localparam logic [31:0] SEC_PER_DAY  = 32'd86400;
  localparam logic [31:0] SEC_YEAR     = 32'd31536000;  // 365 days
  localparam logic [31:0] SEC_LEAPYEAR = 32'd31622400;  // 366 days
  localparam logic [7:0]  BCD_SAT      = 8'h99;
  localparam logic [6:0]  BCD_MAX      = 7'd99;
  localparam logic [3:0]  MONTHS_MAX   = 4'd12;
  localparam logic [3:0]  WEEK_DAYS    = 4'd7;
  localparam logic [2:0]  WEEKDAY_OFS  = 3'd4;  // epoch day zero is a thursday

  // seconds per day is 675 << 7; days = ((secs >> 7) * ceil(2^35 / 675)) >> 35
  localparam int unsigned DAY_SHIFT    = 7;
  localparam logic [25:0] DAY_RECIP    = 26'd50903317;
  localparam int unsigned RECIP_SHIFT  = 35;

  // microcode step addresses
  localparam logic [UPC_W-1:0] S_IDLE      = 4'd0;
  localparam logic [UPC_W-1:0] S_INIT      = 4'd1;
  localparam logic [UPC_W-1:0] S_HOUR      = 4'd2;
  localparam logic [UPC_W-1:0] S_DAY       = 4'd3;
  localparam logic [UPC_W-1:0] S_MON_TEST  = 4'd4;
  localparam logic [UPC_W-1:0] S_MON_LOOP  = 4'd5;
  localparam logic [UPC_W-1:0] S_LEAP      = 4'd6;
  localparam logic [UPC_W-1:0] S_YEAR_TEST = 4'd7;
  localparam logic [UPC_W-1:0] S_YEAR_LOOP = 4'd8;
  localparam logic [UPC_W-1:0] S_DAY_MUL   = 4'd9;
  localparam logic [UPC_W-1:0] S_DAY_MOD   = 4'd10;
  localparam logic [UPC_W-1:0] S_OUT       = 4'd11;
  localparam logic [UPC_W-1:0] S_OUT_WAIT  = 4'd12;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_INIT,
    OP_ADD_HOUR,
    OP_ADD_DAY,
    OP_ADD_MONTH,
    OP_ADD_LEAP,
    OP_ADD_YEAR,
    OP_DAY_MUL,
    OP_DAY_MOD,
    OP_LOAD_OUT
  } op_e;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_ITEM,
    COND_MONTHS_DONE,
    COND_MORE_MONTHS,
    COND_YEARS_DONE,
    COND_MORE_YEARS,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic months_done;
    logic more_months;
    logic years_done;
    logic more_years;
    logic out_free;
  } stat_t;

  // seconds in a whole month, index 0 is january, non-leap
  function automatic logic [31:0] month_secs(input logic [3:0] idx);
    logic [31:0] r;
    case (idx)
      4'd0:    r = 32'd31 * SEC_PER_DAY;
      4'd1:    r = 32'd28 * SEC_PER_DAY;
      4'd2:    r = 32'd31 * SEC_PER_DAY;
      4'd3:    r = 32'd30 * SEC_PER_DAY;
      4'd4:    r = 32'd31 * SEC_PER_DAY;
      4'd5:    r = 32'd30 * SEC_PER_DAY;
      4'd6:    r = 32'd31 * SEC_PER_DAY;
      4'd7:    r = 32'd31 * SEC_PER_DAY;
      4'd8:    r = 32'd30 * SEC_PER_DAY;
      4'd9:    r = 32'd31 * SEC_PER_DAY;
      4'd10:   r = 32'd30 * SEC_PER_DAY;
      4'd11:   r = 32'd31 * SEC_PER_DAY;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // two bcd digits, saturating above 99
  function automatic logic [7:0] to_bcd2(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  tens;
    logic [3:0]  ones;
    p    = 15'(v) * 15'd205;  // v / 10 by reciprocal
    tens = p[14:11];
    ones = 4'(v - 7'(tens) * 7'd10);
    if (v > BCD_MAX) begin
      return BCD_SAT;
    end
    return {tens, ones};
  endfunction

  // day count mod 7 by summing octal digits, 8 is 1 mod 7
  function automatic logic [2:0] mod7_16(input logic [15:0] d);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(d[2:0]) + 6'(d[5:3]) + 6'(d[8:6]) + 6'(d[11:9]) + 6'(d[14:12]) + 6'(d[15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    if (s2 >= WEEK_DAYS) begin
      s2 = s2 - WEEK_DAYS;
    end
    return s2[2:0];
  endfunction

  // day index mod 7 to weekday, 1 is sunday
  function automatic logic [2:0] weekday_of(input logic [2:0] r7);
    logic [3:0] t;
    t = 4'(r7) + 4'(WEEKDAY_OFS);
    if (t >= WEEK_DAYS) begin
      t = t - WEEK_DAYS;
    end
    return 3'(t + 4'd1);
  endfunction

endpackage

// File: src/dre_urom.sv
// ----------------------------------------------------------------------------
// dre_urom
// microcode rom: one control word per step address
// ----------------------------------------------------------------------------
module dre_urom (
  input  logic [dre_pkg::UPC_W-1:0] upc_i,
  output dre_pkg::ctrl_t            ctrl_o
);

  always_comb begin
    case (upc_i)
      dre_pkg::S_IDLE:      ctrl_o = '{dre_pkg::OP_NOP,       dre_pkg::COND_NO_ITEM,
                                       dre_pkg::S_IDLE};
      dre_pkg::S_INIT:      ctrl_o = '{dre_pkg::OP_INIT,      dre_pkg::COND_NEVER,
                                       dre_pkg::S_IDLE};
      dre_pkg::S_HOUR:      ctrl_o = '{dre_pkg::OP_ADD_HOUR,  dre_pkg::COND_NEVER,
                                       dre_pkg::S_IDLE};
      dre_pkg::S_DAY:       ctrl_o = '{dre_pkg::OP_ADD_DAY,   dre_pkg::COND_NEVER,
                                       dre_pkg::S_IDLE};
      dre_pkg::S_MON_TEST:  ctrl_o = '{dre_pkg::OP_NOP,       dre_pkg::COND_MONTHS_DONE,
                                       dre_pkg::S_LEAP};
      dre_pkg::S_MON_LOOP:  ctrl_o = '{dre_pkg::OP_ADD_MONTH, dre_pkg::COND_MORE_MONTHS,
                                       dre_pkg::S_MON_LOOP};
      dre_pkg::S_LEAP:      ctrl_o = '{dre_pkg::OP_ADD_LEAP,  dre_pkg::COND_NEVER,
                                       dre_pkg::S_IDLE};
      dre_pkg::S_YEAR_TEST: ctrl_o = '{dre_pkg::OP_NOP,       dre_pkg::COND_YEARS_DONE,
                                       dre_pkg::S_DAY_MUL};
      dre_pkg::S_YEAR_LOOP: ctrl_o = '{dre_pkg::OP_ADD_YEAR,  dre_pkg::COND_MORE_YEARS,
                                       dre_pkg::S_YEAR_LOOP};
      dre_pkg::S_DAY_MUL:   ctrl_o = '{dre_pkg::OP_DAY_MUL,   dre_pkg::COND_NEVER,
                                       dre_pkg::S_IDLE};
      dre_pkg::S_DAY_MOD:   ctrl_o = '{dre_pkg::OP_DAY_MOD,   dre_pkg::COND_NEVER,
                                       dre_pkg::S_IDLE};
      dre_pkg::S_OUT:       ctrl_o = '{dre_pkg::OP_LOAD_OUT,  dre_pkg::COND_OUT_FREE,
                                       dre_pkg::S_IDLE};
      dre_pkg::S_OUT_WAIT:  ctrl_o = '{dre_pkg::OP_NOP,       dre_pkg::COND_ALWAYS,
                                       dre_pkg::S_OUT};
      default:              ctrl_o = '{dre_pkg::OP_NOP,       dre_pkg::COND_ALWAYS,
                                       dre_pkg::S_IDLE};
    endcase
  end

endmodule

// File: src/dre_seq.sv
// ----------------------------------------------------------------------------
// dre_seq
// step counter with conditional jumps, input handshake
// ----------------------------------------------------------------------------
module dre_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  output logic                      accept_o,
  input  dre_pkg::stat_t            stat_i,
  input  dre_pkg::ctrl_t            ctrl_i,
  output logic [dre_pkg::UPC_W-1:0] upc_o
);

  logic [dre_pkg::UPC_W-1:0] upc_q;
  logic [dre_pkg::UPC_W-1:0] upc_d;
  logic                      take;

  assign in_stall_o = (upc_q != dre_pkg::S_IDLE);
  assign accept_o   = (upc_q == dre_pkg::S_IDLE) && in_valid_i;
  assign upc_o      = upc_q;

  always_comb begin
    case (ctrl_i.cond)
      dre_pkg::COND_NEVER:       take = 1'b0;
      dre_pkg::COND_ALWAYS:      take = 1'b1;
      dre_pkg::COND_NO_ITEM:     take = !in_valid_i;
      dre_pkg::COND_MONTHS_DONE: take = stat_i.months_done;
      dre_pkg::COND_MORE_MONTHS: take = stat_i.more_months;
      dre_pkg::COND_YEARS_DONE:  take = stat_i.years_done;
      dre_pkg::COND_MORE_YEARS:  take = stat_i.more_years;
      dre_pkg::COND_OUT_FREE:    take = stat_i.out_free;
      default:                   take = 1'b1;
    endcase
    upc_d = take ? ctrl_i.target : upc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= dre_pkg::S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// File: src/dre_dp.sv
// ----------------------------------------------------------------------------
// dre_dp
// datapath: seconds accumulator, month and year counters, day count by
// reciprocal multiply with a mod-7 fold, output register
// ----------------------------------------------------------------------------
module dre_dp #(
  parameter int unsigned EPOCH_YEAR = dre_pkg::EPOCH_YEAR_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  dre_pkg::ctrl_t ctrl_i,
  output dre_pkg::stat_t stat_o,
  input  logic [5:0]     second_value_i,
  input  logic [5:0]     minute_value_i,
  input  logic [4:0]     hour_value_i,
  input  logic [4:0]     day_of_month_i,
  input  logic [3:0]     month_value_i,
  input  logic [11:0]    full_year_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     second_bcd_o,
  output logic [7:0]     minute_bcd_o,
  output logic [7:0]     hour_bcd_o,
  output logic [7:0]     date_bcd_o,
  output logic [7:0]     month_bcd_o,
  output logic [7:0]     year_low_bcd_o,
  output logic [7:0]     century_bcd_o,
  output logic [2:0]     weekday_number_o,
  output logic [31:0]    epoch_seconds_o
);

  localparam logic [11:0] EPOCH_Y   = 12'(EPOCH_YEAR);

  // captured word
  logic [5:0]  sec_q;
  logic [5:0]  min_q;
  logic [4:0]  hour_q;
  logic [4:0]  day_q;
  logic [3:0]  mon_q;
  logic [11:0] yr_q;

  logic [5:0]  cent_q;
  logic [6:0]  ylo_q;
  logic [31:0] acc_q;
  logic [11:0] y_q;
  logic [3:0]  mcnt_q;
  logic [50:0] prod_q;
  logic [2:0]  r7_q;

  logic        out_valid_q;
  logic [7:0]  sec_bcd_q;
  logic [7:0]  min_bcd_q;
  logic [7:0]  hour_bcd_q;
  logic [7:0]  date_bcd_q;
  logic [7:0]  mon_bcd_q;
  logic [7:0]  ylo_bcd_q;
  logic [7:0]  cent_bcd_q;
  logic [2:0]  wday_q;
  logic [31:0] es_q;

  logic [3:0]  full_months;
  logic [24:0] cent_prod;
  logic [12:0] y_next;
  logic        load_out;

  always_comb begin
    // whole months before the current one, capped at a full year
    if (mon_q == 4'd0) begin
      full_months = 4'd0;
    end else if (mon_q - 4'd1 > dre_pkg::MONTHS_MAX) begin
      full_months = dre_pkg::MONTHS_MAX;
    end else begin
      full_months = mon_q - 4'd1;
    end
    cent_prod = 25'(yr_q) * 25'd5243;  // yr / 100 by reciprocal
    y_next    = 13'(y_q) + 13'd1;
    load_out  = (ctrl_i.op == dre_pkg::OP_LOAD_OUT) && stat_o.out_free;
  end

  assign stat_o.months_done = (mcnt_q >= full_months);
  assign stat_o.more_months = (5'(mcnt_q) + 5'd1 < 5'(full_months));
  assign stat_o.years_done  = (y_q >= yr_q);
  assign stat_o.more_years  = (y_next < 13'(yr_q));
  assign stat_o.out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      sec_q  <= second_value_i;
      min_q  <= minute_value_i;
      hour_q <= hour_value_i;
      day_q  <= day_of_month_i;
      mon_q  <= month_value_i;
      yr_q   <= full_year_i;
    end
    case (ctrl_i.op)
      dre_pkg::OP_INIT: begin
        acc_q  <= 32'(sec_q) + 32'(12'(min_q) * 12'd60);
        cent_q <= cent_prod[24:19];
        y_q    <= EPOCH_Y;
        mcnt_q <= 4'd0;
      end
      dre_pkg::OP_ADD_HOUR: begin
        acc_q <= acc_q + 32'(17'(hour_q) * 17'd3600);
        ylo_q <= 7'(yr_q - 12'(cent_q) * 12'd100);
      end
      dre_pkg::OP_ADD_DAY: begin
        // day of month counts from one; day zero wraps
        acc_q <= acc_q + 32'(day_q) * dre_pkg::SEC_PER_DAY - dre_pkg::SEC_PER_DAY;
      end
      dre_pkg::OP_ADD_MONTH: begin
        acc_q  <= acc_q + dre_pkg::month_secs(mcnt_q);
        mcnt_q <= mcnt_q + 4'd1;
      end
      dre_pkg::OP_ADD_LEAP: begin
        if (yr_q[1:0] == 2'd0 && mon_q > 4'd2) begin
          acc_q <= acc_q + dre_pkg::SEC_PER_DAY;
        end
      end
      dre_pkg::OP_ADD_YEAR: begin
        acc_q <= acc_q + ((y_q[1:0] == 2'd0) ? dre_pkg::SEC_LEAPYEAR : dre_pkg::SEC_YEAR);
        y_q   <= y_next[11:0];
      end
      dre_pkg::OP_DAY_MUL: begin
        // exact quotient by 675 for any 25-bit value
        prod_q <= 51'(acc_q[31:dre_pkg::DAY_SHIFT]) * 51'(dre_pkg::DAY_RECIP);
      end
      dre_pkg::OP_DAY_MOD: begin
        r7_q <= dre_pkg::mod7_16(prod_q[dre_pkg::RECIP_SHIFT +: 16]);
      end
      default: begin
      end
    endcase
    if (load_out) begin
      sec_bcd_q  <= dre_pkg::to_bcd2(7'(sec_q));
      min_bcd_q  <= dre_pkg::to_bcd2(7'(min_q));
      hour_bcd_q <= dre_pkg::to_bcd2(7'(hour_q));
      date_bcd_q <= dre_pkg::to_bcd2(7'(day_q));
      mon_bcd_q  <= dre_pkg::to_bcd2(7'(mon_q));
      ylo_bcd_q  <= dre_pkg::to_bcd2(ylo_q);
      cent_bcd_q <= dre_pkg::to_bcd2(7'(cent_q));
      wday_q     <= dre_pkg::weekday_of(r7_q);
      es_q       <= acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign second_bcd_o     = sec_bcd_q;
  assign minute_bcd_o     = min_bcd_q;
  assign hour_bcd_o       = hour_bcd_q;
  assign date_bcd_o       = date_bcd_q;
  assign month_bcd_o      = mon_bcd_q;
  assign year_low_bcd_o   = ylo_bcd_q;
  assign century_bcd_o    = cent_bcd_q;
  assign weekday_number_o = wday_q;
  assign epoch_seconds_o  = es_q;

endmodule

// File: src/date_to_rtc_image_and_epoch_top.sv
// ----------------------------------------------------------------------------
// date_to_rtc_image_and_epoch_top
// binary calendar time to clock register image, epoch seconds and weekday
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_stall_o carry one calendar word (second,
// minute, hour, day, month, four-digit year). output channel: out_valid_o /
// out_stall_i carry one result word: seven bcd register fields, the weekday
// (1 is sunday) and the seconds since 1 january of EPOCH_YEAR.
// a word is taken on a clock edge with valid high and stall low.
// one input word gives exactly one output word. a small microcode program
// steps a shared adder: four setup steps, one step per whole month (up to
// 12), one step per year between EPOCH_YEAR and the given year, then a
// reciprocal multiply and a mod-7 fold of the day count for the weekday.
// years before EPOCH_YEAR count as zero year steps, and the year loop
// dominates the time a word takes. in_stall_o is low only while the
// sequencer sits at its idle step, which it returns to as soon as the
// result is placed in the output register. a stalled result stays in the
// output register; the next word can be taken and worked on meanwhile,
// and waits in the output steps until the register frees up. reset
// empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module date_to_rtc_image_and_epoch_top #(
  parameter int unsigned EPOCH_YEAR = dre_pkg::EPOCH_YEAR_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [5:0]  second_value_i,
  input  logic [5:0]  minute_value_i,
  input  logic [4:0]  hour_value_i,
  input  logic [4:0]  day_of_month_i,
  input  logic [3:0]  month_value_i,
  input  logic [11:0] full_year_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  second_bcd_o,
  output logic [7:0]  minute_bcd_o,
  output logic [7:0]  hour_bcd_o,
  output logic [7:0]  date_bcd_o,
  output logic [7:0]  month_bcd_o,
  output logic [7:0]  year_low_bcd_o,
  output logic [7:0]  century_bcd_o,
  output logic [2:0]  weekday_number_o,
  output logic [31:0] epoch_seconds_o
);

  logic [dre_pkg::UPC_W-1:0] upc;
  dre_pkg::ctrl_t            ctrl;
  dre_pkg::stat_t            stat;
  logic                      accept;

  dre_urom u_urom (
    .upc_i  (upc),
    .ctrl_o (ctrl)
  );

  dre_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .accept_o   (accept),
    .stat_i     (stat),
    .ctrl_i     (ctrl),
    .upc_o      (upc)
  );

  dre_dp #(
    .EPOCH_YEAR (EPOCH_YEAR)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .second_value_i   (second_value_i),
    .minute_value_i   (minute_value_i),
    .hour_value_i     (hour_value_i),
    .day_of_month_i   (day_of_month_i),
    .month_value_i    (month_value_i),
    .full_year_i      (full_year_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .second_bcd_o     (second_bcd_o),
    .minute_bcd_o     (minute_bcd_o),
    .hour_bcd_o       (hour_bcd_o),
    .date_bcd_o       (date_bcd_o),
    .month_bcd_o      (month_bcd_o),
    .year_low_bcd_o   (year_low_bcd_o),
    .century_bcd_o    (century_bcd_o),
    .weekday_number_o (weekday_number_o),
    .epoch_seconds_o  (epoch_seconds_o)
  );

endmodule

// File: src/dre_checker.sv
// ----------------------------------------------------------------------------
// dre_checker
// port-level checks for the date to clock image block, bound to the top level
// ----------------------------------------------------------------------------
module dre_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  second_bcd_o,
  input logic [7:0]  year_low_bcd_o,
  input logic [2:0]  weekday_number_o
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // one word at a time: taking a word closes the input
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input still open after taking a word");

  a_weekday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> weekday_number_o != 3'd0)
    else $error("weekday out of range");

  a_bcd_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> second_bcd_o[3:0] <= 4'd9 && second_bcd_o[7:4] <= 4'd9
                    && year_low_bcd_o[3:0] <= 4'd9 && year_low_bcd_o[7:4] <= 4'd9)
    else $error("bcd digit above nine");

endmodule

bind date_to_rtc_image_and_epoch_top dre_checker u_dre_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .second_bcd_o     (second_bcd_o),
  .year_low_bcd_o   (year_low_bcd_o),
  .weekday_number_o (weekday_number_o)
);
